/* hdl/numeric_token_classifier_macros.svh */
// Assertion macros shared by the numeric token classifier modules.
// Each expects a clock named clk and a reset named rst in the using module.
`ifndef NUMERIC_TOKEN_CLASSIFIER_MACROS_SVH
`define NUMERIC_TOKEN_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NTC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define NTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/ntc_pkg.sv */
// Shared types and constants for the numeric token classifier.
// Used by ntc_front, ntc_queue, ntc_back and the top level.
package ntc_pkg;

  localparam int QueueDepth = 4;

  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [7:0] CharNine  = 8'd57;

  // Character kinds carried through the queue; spaces never enter it.
  localparam logic [2:0] KIND_DOT   = 3'd0;
  localparam logic [2:0] KIND_DIGIT = 3'd1;
  localparam logic [2:0] KIND_MINUS = 3'd2;
  localparam logic [2:0] KIND_PLUS  = 3'd3;
  localparam logic [2:0] KIND_OTHER = 3'd4;
  localparam logic [2:0] KIND_TERM  = 3'd5;

  localparam logic [1:0] CLASS_INTEGER = 2'd0;
  localparam logic [1:0] CLASS_DECIMAL = 2'd1;
  localparam logic [1:0] CLASS_TEXT    = 2'd2;
  localparam logic [1:0] CLASS_MIXED   = 2'd3;

  typedef struct packed {
    logic [2:0] kind;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* hdl/numeric_token_classifier.sv */
// Numeric token classifier: one byte per beat in, one class per terminator out.
// Throughput: one beat per cycle; while a class waits, a terminator holds at the
// queue head, later beats fill the QUEUE_DEPTH queue, then in_ready drops but for spaces.
// Accepted terminators pass the queue head, then set out_valid when the slot is free.
// Reset (rst, synchronous): empties the token queue, clears string state and
// drops out_valid.
module numeric_token_classifier
  import ntc_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] char_code,
  input  logic       end_of_string,
  input  logic       in_valid,
  output logic       in_ready,
  output logic [1:0] token_class,
  output logic       out_valid,
  input  logic       out_ready
);

  q_status_t q_status;
  logic      push;
  logic      pop;
  entry_t    push_entry;
  entry_t    head;

  ntc_front u_front (
    .char_code     (char_code),
    .end_of_string (end_of_string),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .q_status      (q_status),
    .push          (push),
    .push_entry    (push_entry)
  );

  ntc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_status   (q_status)
  );

  ntc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_status    (q_status),
    .head        (head),
    .pop         (pop),
    .token_class (token_class),
    .out_valid   (out_valid),
    .out_ready   (out_ready)
  );

endmodule

/* hdl/ntc_front.sv */
// Front end: accepts input beats and decodes each byte into a token kind.
// Depends on ntc_pkg; pushes into ntc_queue.
module ntc_front
  import ntc_pkg::*;
(
  input  logic [7:0] char_code,
  input  logic       end_of_string,
  input  logic       in_valid,
  output logic       in_ready,
  input  q_status_t  q_status,
  output logic       push,
  output entry_t     push_entry
);

  logic is_space;

  assign is_space = !end_of_string && (char_code == CharSpace);

  // Spaces are taken even when the queue is full: they change nothing.
  assign in_ready = !q_status.full || is_space;
  assign push     = in_valid && !q_status.full && !is_space;

  always_comb begin
    if (end_of_string) begin
      push_entry.kind = KIND_TERM;
    end else if (char_code == CharDot) begin
      push_entry.kind = KIND_DOT;
    end else if (char_code inside {[CharZero:CharNine]}) begin
      push_entry.kind = KIND_DIGIT;
    end else if (char_code == CharMinus) begin
      push_entry.kind = KIND_MINUS;
    end else if (char_code == CharPlus) begin
      push_entry.kind = KIND_PLUS;
    end else begin
      push_entry.kind = KIND_OTHER;
    end
  end

endmodule

/* hdl/ntc_queue.sv */
// Short FIFO of decoded token kinds between front and back ends.
// Depends on ntc_pkg and the assertion macro header.
`include "numeric_token_classifier_macros.svh"
module ntc_queue
  import ntc_pkg::*;
#(
  parameter int DEPTH = QueueDepth
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  entry_t    push_entry,
  input  logic      pop,
  output entry_t    head,
  output q_status_t q_status
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  entry_t            mem [DEPTH];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign q_status.full  = (count == CntW'(DEPTH));
  assign q_status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // Load the head: the next stored beat after a pop, or the incoming beat
  // when it lands in a queue that is empty or being emptied.
  always_ff @(posedge clk) begin
    if (pop && (count > CntW'(1))) begin
      head <= mem[wrap_inc(rd_ptr)];
    end else if (push && (pop || q_status.empty)) begin
      head <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wrap_inc(wr_ptr);
      if (pop)  rd_ptr <= wrap_inc(rd_ptr);
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `NTC_ASSERT_NOW(a_count_bound, 1'b1, count <= CntW'(DEPTH), "queue count over depth")
  `NTC_ASSERT_NOW(a_no_pop_empty, pop, !q_status.empty, "pop from empty queue")
  `NTC_ASSERT_NEXT(a_drain, pop && !push, count == $past(count) - 1'b1, "count did not drop")

endmodule

/* hdl/ntc_back.sv */
// Back end: applies token kinds to the string state and issues the class.
// Depends on ntc_pkg and the assertion macro header.
`include "numeric_token_classifier_macros.svh"
module ntc_back
  import ntc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  q_status_t  q_status,
  input  entry_t     head,
  output logic       pop,
  output logic [1:0] token_class,
  output logic       out_valid,
  input  logic       out_ready
);

  logic       stopped, stopped_next;
  logic       digit_seen, digit_seen_next;
  logic       other_seen, other_seen_next;
  logic [1:0] dot_count, dot_count_next;
  logic [1:0] minus_count, minus_count_next;
  logic [1:0] plus_count, plus_count_next;
  logic       is_term;
  logic       slot_free;
  logic [1:0] class_now;
  logic       any_mark;

  function automatic logic [1:0] sat_inc(input logic [1:0] c);
    return (c >= 2'd2) ? 2'd2 : c + 2'd1;
  endfunction

  assign is_term   = (head.kind == KIND_TERM);
  assign slot_free = !out_valid || out_ready;
  // Characters drain freely; a terminator waits for the output slot.
  assign pop       = !q_status.empty && (!is_term || slot_free);
  assign any_mark  = (plus_count != '0) || (minus_count != '0) || (dot_count != '0);

  always_comb begin
    if (stopped) begin
      class_now = CLASS_MIXED;
    end else if (other_seen || !digit_seen) begin
      class_now = CLASS_TEXT;
    end else if (dot_count != '0) begin
      class_now = CLASS_DECIMAL;
    end else begin
      class_now = CLASS_INTEGER;
    end
  end

  always_comb begin
    stopped_next     = stopped;
    digit_seen_next  = digit_seen;
    other_seen_next  = other_seen;
    dot_count_next   = dot_count;
    minus_count_next = minus_count;
    plus_count_next  = plus_count;
    if (is_term) begin
      stopped_next     = 1'b0;
      digit_seen_next  = 1'b0;
      other_seen_next  = 1'b0;
      dot_count_next   = '0;
      minus_count_next = '0;
      plus_count_next  = '0;
    end else if (!stopped) begin
      case (head.kind)
        KIND_DOT: begin
          dot_count_next = sat_inc(dot_count);
          if (dot_count_next >= 2'd2) begin
            other_seen_next = 1'b1;
            if (digit_seen) stopped_next = 1'b1;
          end
        end
        KIND_DIGIT: begin
          digit_seen_next = 1'b1;
          if (other_seen) stopped_next = 1'b1;
        end
        KIND_MINUS: begin
          minus_count_next = sat_inc(minus_count);
          if (minus_count_next >= 2'd2 || plus_count != '0 || dot_count != '0) begin
            other_seen_next = 1'b1;
          end
          if (digit_seen) stopped_next = 1'b1;
        end
        KIND_PLUS: begin
          plus_count_next = sat_inc(plus_count);
          if (plus_count_next >= 2'd2 || minus_count != '0 || dot_count != '0) begin
            other_seen_next = 1'b1;
          end
          if (digit_seen) stopped_next = 1'b1;
        end
        default: begin
          if (digit_seen) begin
            stopped_next = 1'b1;
          end else begin
            other_seen_next = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stopped     <= 1'b0;
      digit_seen  <= 1'b0;
      other_seen  <= 1'b0;
      dot_count   <= '0;
      minus_count <= '0;
      plus_count  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (pop) begin
        stopped     <= stopped_next;
        digit_seen  <= digit_seen_next;
        other_seen  <= other_seen_next;
        dot_count   <= dot_count_next;
        minus_count <= minus_count_next;
        plus_count  <= plus_count_next;
      end
      if (pop && is_term) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_term) begin
      token_class <= class_now;
    end
  end

  `NTC_ASSERT_NOW(a_stop_needs_digit, stopped, digit_seen, "stopped without a digit")
  `NTC_ASSERT_NEXT(a_term_clears, pop && is_term,
    out_valid && !stopped && !digit_seen && !other_seen && !any_mark,
    "terminator did not clear state or raise result")
  `NTC_ASSERT_NOW(a_no_overwrite, pop && is_term, slot_free, "result overwritten")

endmodule

/* sim/testbench.sv */
// Self-checking testbench for numeric_token_classifier: directed strings, then random ones.
// Checks every class against a local scanner model or, for typed rows, the table's class.
// Depends on ntc_pkg and the RTL under hdl/.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ntc_pkg::*;

  typedef struct packed {
    logic       stopped;
    logic       digit_seen;
    logic       other_seen;
    logic [1:0] dots;
    logic [1:0] minuses;
    logic [1:0] pluses;
  } scan_state_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eos;
    logic       typed;
    logic [1:0] want;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic [7:0] char_code = 8'h00;
  logic       end_of_string = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] token_class;
  logic       out_valid;
  logic       out_ready = 1'b0;

  // class fixed by the stimulus table, travels with the terminator beat
  logic       typed_valid = 1'b0;
  logic [1:0] typed_class = CLASS_INTEGER;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned beat_count = 0;
  int unsigned fail_count = 0;

  scan_state_t scan_state = '0;
  logic [1:0]  pending_classes[$];
  logic [1:0]  oldest_class;

  stim_row_t directed_rows[25] = '{
    '{8'h00,     1'b1, 1'b1, CLASS_TEXT},     // empty string
    '{"0",       1'b0, 1'b0, CLASS_INTEGER},
    '{"9",       1'b0, 1'b0, CLASS_INTEGER},
    '{8'hFF,     1'b1, 1'b1, CLASS_INTEGER},  // terminator byte is ignored
    '{CharMinus, 1'b0, 1'b0, CLASS_INTEGER},
    '{"1",       1'b0, 1'b0, CLASS_INTEGER},
    '{CharDot,   1'b0, 1'b0, CLASS_INTEGER},
    '{"5",       1'b0, 1'b0, CLASS_INTEGER},
    '{8'h00,     1'b1, 1'b0, CLASS_INTEGER},
    '{"a",       1'b0, 1'b0, CLASS_INTEGER},
    '{"1",       1'b0, 1'b0, CLASS_INTEGER},
    '{8'h00,     1'b1, 1'b1, CLASS_MIXED},
    '{8'h00,     1'b0, 1'b0, CLASS_INTEGER},  // NUL is an ordinary character
    '{8'h00,     1'b1, 1'b1, CLASS_TEXT},
    '{8'hFF,     1'b0, 1'b0, CLASS_INTEGER},  // high bytes too
    '{8'h00,     1'b1, 1'b1, CLASS_TEXT},
    '{CharSpace, 1'b0, 1'b0, CLASS_INTEGER},  // blank string
    '{8'h00,     1'b1, 1'b1, CLASS_TEXT},
    '{"7",       1'b0, 1'b0, CLASS_INTEGER},
    '{CharDot,   1'b0, 1'b0, CLASS_INTEGER},
    '{CharDot,   1'b0, 1'b0, CLASS_INTEGER},
    '{8'h00,     1'b1, 1'b1, CLASS_MIXED},
    '{CharPlus,  1'b0, 1'b0, CLASS_INTEGER},
    '{CharPlus,  1'b0, 1'b0, CLASS_INTEGER},
    '{8'h00,     1'b1, 1'b0, CLASS_INTEGER}
  };

  numeric_token_classifier u_dut (
    .clk          (clk),
    .rst          (rst),
    .char_code    (char_code),
    .end_of_string(end_of_string),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .token_class  (token_class),
    .out_valid    (out_valid),
    .out_ready    (out_ready)
  );

  always #5 clk = ~clk;

  function automatic logic [1:0] bump(logic [1:0] n);
    return (n >= 2'd2) ? 2'd2 : n + 2'd1;
  endfunction

  function automatic scan_state_t absorb_char(scan_state_t s, logic [7:0] ch);
    if (s.stopped || ch == CharSpace) return s;
    if (ch == CharDot) begin
      s.dots = bump(s.dots);
      if (s.dots == 2'd2) begin
        s.other_seen = 1'b1;
        if (s.digit_seen) s.stopped = 1'b1;
      end
    end else if (ch >= CharZero && ch <= CharNine) begin
      s.digit_seen = 1'b1;
      if (s.other_seen) s.stopped = 1'b1;
    end else if (ch == CharMinus) begin
      s.minuses = bump(s.minuses);
      if (s.minuses == 2'd2 || s.pluses != 2'd0 || s.dots != 2'd0) s.other_seen = 1'b1;
      if (s.digit_seen) s.stopped = 1'b1;
    end else if (ch == CharPlus) begin
      s.pluses = bump(s.pluses);
      if (s.pluses == 2'd2 || s.minuses != 2'd0 || s.dots != 2'd0) s.other_seen = 1'b1;
      if (s.digit_seen) s.stopped = 1'b1;
    end else if (s.digit_seen) begin
      s.stopped = 1'b1;
    end else begin
      s.other_seen = 1'b1;
    end
    return s;
  endfunction

  function automatic logic [1:0] class_of(scan_state_t s);
    if (s.stopped) return CLASS_MIXED;
    if (s.other_seen || !s.digit_seen) return CLASS_TEXT;
    if (s.dots != 2'd0) return CLASS_DECIMAL;
    return CLASS_INTEGER;
  endfunction

  task automatic note_failure(string what, logic [1:0] want, logic [1:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: %s: expected class %0d, got %0d", $time, what, want, got);
  endtask

  // Check results against the oldest pending class, then track accepted beats.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_classes.size() == 0) begin
          note_failure("class with no terminator pending", 2'd0, token_class);
        end else begin
          oldest_class = pending_classes.pop_front();
          if (token_class !== oldest_class)
            note_failure("token_class", oldest_class, token_class);
        end
      end
      if (in_valid && in_ready) begin
        if (end_of_string) begin
          pending_classes.push_back(typed_valid ? typed_class : class_of(scan_state));
          scan_state = '0;
        end else begin
          scan_state = absorb_char(scan_state, char_code);
        end
      end
    end
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  task automatic send_beat(logic [7:0] ch, logic eos, logic typed, logic [1:0] want);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid      <= 1'b1;
    char_code     <= ch;
    end_of_string <= eos;
    typed_valid   <= typed;
    typed_class   <= want;
    do @(posedge clk); while (!in_ready);
    beat_count++;
  endtask

  function automatic logic [7:0] any_char();
    case ($urandom_range(6))
      0:       return 8'($urandom_range(48, 57));
      1:       return CharDot;
      2:       return CharMinus;
      3:       return CharPlus;
      4:       return CharSpace;
      5:       return 8'($urandom_range(97, 122));
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly number-shaped strings, some mutated; the rest loose characters or raw bytes.
  task automatic send_string();
    logic [7:0]  chars[$];
    int unsigned mode;
    int unsigned n;
    mode = $urandom_range(99);
    if (mode < 60) begin
      if ($urandom_range(3) == 0) chars.push_back($urandom_range(1) ? CharMinus : CharPlus);
      n = $urandom_range(1, 4);
      repeat (n) chars.push_back(8'($urandom_range(48, 57)));
      if ($urandom_range(1) == 1) begin
        chars.push_back(CharDot);
        n = $urandom_range(0, 3);
        repeat (n) chars.push_back(8'($urandom_range(48, 57)));
      end
      if ($urandom_range(4) == 0) chars[$urandom_range(chars.size() - 1)] = any_char();
      if ($urandom_range(9) == 0) chars.insert($urandom_range(chars.size()), CharSpace);
    end else if (mode < 85) begin
      n = $urandom_range(1, 8);
      repeat (n) chars.push_back(any_char());
    end else begin
      n = $urandom_range(0, 6);
      repeat (n) chars.push_back(8'($urandom));
    end
    foreach (chars[i]) send_beat(chars[i], 1'b0, 1'b0, CLASS_INTEGER);
    send_beat(8'($urandom), 1'b1, 1'b0, CLASS_INTEGER);
  endtask

  int unsigned idle_plan[4]  = '{0, 53, 0, 32};
  int unsigned stall_plan[4] = '{0, 0, 53, 32};

  initial begin
    int unsigned n;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed_rows[i])
      send_beat(directed_rows[i].ch, directed_rows[i].eos, directed_rows[i].typed,
                directed_rows[i].want);
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_plan[p];
      stall_pct     = stall_plan[p];
      while (beat_count < 25 + (p + 1) * 400) send_string();
    end
    in_valid  <= 1'b0;
    stall_pct = 0;
    for (n = 0; n < 20000 && pending_classes.size() != 0; n++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_classes.size() != 0)
      note_failure("class never delivered", pending_classes[0], 2'd0);
    if (fail_count == 0)
      $display("numeric_token_classifier: match");
    else
      $display("numeric_token_classifier: mismatch");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("numeric_token_classifier: mismatch");
    $finish;
  end

endmodule
